[hdl/ternary_bitplane_similarity_macros.svh]
// assertion macros for the ternary bit-plane similarity scorer
`ifndef TERNARY_BITPLANE_SIMILARITY_MACROS_SVH
`define TERNARY_BITPLANE_SIMILARITY_MACROS_SVH

// property checked outside reset
`define TBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define TBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tbs_pkg.sv]
// shared types, constants and helpers of the ternary bit-plane similarity scorer
`timescale 1ns / 1ps
package tbs_pkg;

  // parameter defaults
  localparam int DEF_MAX_WORDS = 64;
  localparam int DEF_WORD_BITS = 64;

  // fixed field widths
  localparam int OP_W    = 1;
  localparam int IDX_W   = 6;
  localparam int PLANE_W = 64;
  localparam int SCORE_W = 15;
  localparam int DOC_W   = 16;
  localparam int WPV_W   = 7;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int WPV_RESET = 1;
  localparam logic REG_WPV = 1'b0;

  // opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 1'b0,
    OP_DOC  = 1'b1
  } op_e;

  // lane geometry
  localparam int LANE_BITS = 8;
  localparam int LANE_CW   = $clog2(LANE_BITS + 1);
  localparam int LANE_DW   = $clog2(2 * LANE_BITS + 1) + 1;
  typedef logic signed [LANE_DW-1:0] lane_delta_t;

  // score range
  localparam int SUM_W     = SCORE_W + 1;
  localparam int SCORE_MAX = 8192;
  localparam int SCORE_MIN = -8192;
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(SCORE_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(SCORE_MIN);

  // per-beat control carried down the pipeline
  typedef struct packed {
    logic             last;
    logic             fresh;
    logic [DOC_W-1:0] doc_index;
  } tbs_ctrl_t;

  function automatic logic [LANE_CW-1:0] popcnt(input logic [LANE_BITS-1:0] v);
    logic [LANE_CW-1:0] n;
    n = '0;
    for (int i = 0; i < LANE_BITS; i++) begin
      n = n + LANE_CW'(v[i]);
    end
    return n;
  endfunction

endpackage

[hdl/tbs_if.sv]
// valid/ready channel interfaces of the scorer
`timescale 1ns / 1ps
interface tbs_in_if import tbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [IDX_W-1:0]   word_index;
  logic [PLANE_W-1:0] pos_bits;
  logic [PLANE_W-1:0] neg_bits;

  modport source (output valid, op, word_index, pos_bits, neg_bits, input ready);
  modport sink (input valid, op, word_index, pos_bits, neg_bits, output ready);
endinterface

interface tbs_out_if import tbs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic [DOC_W-1:0]          doc_index;

  modport source (output valid, score, doc_index, input ready);
  modport sink (input valid, score, doc_index, output ready);
endinterface

[hdl/ternary_bitplane_similarity.sv]
// top level of the ternary bit-plane similarity scorer
//
//   channel   dir   handshake            payload
//   in_i      in    valid/ready          op, word_index, pos_bits, neg_bits
//   out_o     out   valid/ready          score, doc_index
//   apb       in    psel/penable/pready  paddr, pwdata, prdata (words_per_vector)
//
// one beat per cycle sustained while input ready is high; a document word that
// closes a vector raises the score beat through the query read, lane counts and
// merge into the output register. asynchronous active-low reset clears all state
// but the stage payloads, the score payload and the query store. a stalled output
// beat parks in the output register, partial words keep flowing, and input ready
// drops only once the two stages behind a waiting final word are full.
`timescale 1ns / 1ps
module ternary_bitplane_similarity import tbs_pkg::*; #(
  parameter int MAX_WORDS = DEF_MAX_WORDS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tbs_in_if.sink            in_i,
  tbs_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW        = (AW + 1 > WPV_W) ? AW + 1 : WPV_W;
  localparam int NUM_LANES = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
  localparam int PAD_W     = NUM_LANES * LANE_BITS;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [WPV_W-1:0] wpv_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WPV);
  assign prdata = (paddr[2] == REG_WPV) ? APB_DW'(wpv_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpv_q <= WPV_W'(WPV_RESET);
    end else if (cfg_wr) begin
      wpv_q <= pwdata[WPV_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // front end: word position, document number, fresh-vector flag
  // ---------------------------------------------------------------------------
  logic             s1_ready, s2_ready, merge_take;
  logic             in_acc, load_acc, doc_acc;
  logic [AW-1:0]    pos_q, pos_d, pos_sel;
  logic [DOC_W-1:0] doc_cnt_q, doc_cnt_d;
  logic             fresh_q, fresh_d;
  logic [CW-1:0]    wpv_ext, vec_len;
  logic             is_last;
  logic             wr_en;

  assign in_i.ready = s1_ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_acc   = in_acc && (in_i.op == OP_LOAD);
  assign doc_acc    = in_acc && (in_i.op == OP_DOC);

  // vector length clamped to 1..MAX_WORDS
  always_comb begin
    wpv_ext = CW'(wpv_q);
    if (wpv_ext == '0) begin
      vec_len = CW'(1);
    end else if (wpv_ext > CW'(MAX_WORDS)) begin
      vec_len = CW'(MAX_WORDS);
    end else begin
      vec_len = wpv_ext;
    end
  end

  // a leftover position past a shortened vector restarts at word zero
  assign pos_sel = (CW'(pos_q) >= vec_len) ? '0 : pos_q;
  assign is_last = (CW'(pos_sel) + CW'(1)) >= vec_len;

  always_comb begin
    pos_d     = pos_q;
    doc_cnt_d = doc_cnt_q;
    fresh_d   = fresh_q;
    if (load_acc) begin
      pos_d     = '0;
      doc_cnt_d = '0;
      fresh_d   = 1'b1;
    end else if (doc_acc) begin
      if (is_last) begin
        pos_d     = '0;
        doc_cnt_d = doc_cnt_q + DOC_W'(1);
        fresh_d   = 1'b1;
      end else begin
        pos_d   = pos_sel + AW'(1);
        fresh_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      doc_cnt_q <= '0;
      fresh_q   <= 1'b1;
    end else begin
      pos_q     <= pos_d;
      doc_cnt_q <= doc_cnt_d;
      fresh_q   <= fresh_d;
    end
  end

  // ---------------------------------------------------------------------------
  // query store: loads write, document beats read at the current position
  // ---------------------------------------------------------------------------
  logic [2*WORD_BITS-1:0] q_rd_data;

  assign wr_en = load_acc && (int'(in_i.word_index) < MAX_WORDS);

  tbs_query_mem #(
    .DEPTH  (MAX_WORDS),
    .DATA_W (2 * WORD_BITS)
  ) u_qmem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(in_i.word_index)),
    .wr_data_i ({in_i.neg_bits[WORD_BITS-1:0], in_i.pos_bits[WORD_BITS-1:0]}),
    .rd_en_i   (doc_acc),
    .rd_addr_i (pos_sel),
    .rd_data_o (q_rd_data)
  );

  // ---------------------------------------------------------------------------
  // stage 1: document planes alongside the query read
  // ---------------------------------------------------------------------------
  logic                 s1_v_q;
  tbs_ctrl_t            s1_ctrl_q;
  logic [WORD_BITS-1:0] s1_dp_q, s1_dn_q;
  logic                 s1_adv;

  assign s1_adv   = s1_v_q && s2_ready;
  assign s1_ready = !s1_v_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (doc_acc) begin
      s1_v_q <= 1'b1;
    end else if (s2_ready) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (doc_acc) begin
      s1_ctrl_q <= '{last: is_last, fresh: fresh_q, doc_index: doc_cnt_q};
      s1_dp_q   <= in_i.pos_bits[WORD_BITS-1:0];
      s1_dn_q   <= in_i.neg_bits[WORD_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: lanes, each counting one slice of the planes
  // ---------------------------------------------------------------------------
  logic [PAD_W-1:0] qp_pad, qn_pad, dp_pad, dn_pad;
  lane_delta_t      lane_delta [NUM_LANES];
  logic             s2_v_q;
  tbs_ctrl_t        s2_ctrl_q;

  // unused high bits of the last lane read as zero
  assign qp_pad = PAD_W'(q_rd_data[WORD_BITS-1:0]);
  assign qn_pad = PAD_W'(q_rd_data[2*WORD_BITS-1:WORD_BITS]);
  assign dp_pad = PAD_W'(s1_dp_q);
  assign dn_pad = PAD_W'(s1_dn_q);

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    tbs_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (s1_adv),
      .qp_i    (qp_pad[l*LANE_BITS +: LANE_BITS]),
      .qn_i    (qn_pad[l*LANE_BITS +: LANE_BITS]),
      .dp_i    (dp_pad[l*LANE_BITS +: LANE_BITS]),
      .dn_i    (dn_pad[l*LANE_BITS +: LANE_BITS]),
      .delta_o (lane_delta[l])
    );
  end

  assign s2_ready = !s2_v_q || merge_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s1_adv) begin
      s2_v_q <= 1'b1;
    end else if (merge_take) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_ctrl_q <= s1_ctrl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: merge lanes, accumulate, hold the score beat
  // ---------------------------------------------------------------------------
  tbs_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_v_q),
    .ctrl_i      (s2_ctrl_q),
    .delta_i     (lane_delta),
    .take_o      (merge_take),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .score_o     (out_o.score),
    .doc_index_o (out_o.doc_index)
  );

endmodule

[hdl/tbs_query_mem.sv]
// query word store, one write and one registered read port
`timescale 1ns / 1ps
module tbs_query_mem import tbs_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_WORDS,
  parameter int DATA_W = 2 * DEF_WORD_BITS
) (
  input  logic                                      clk_i,
  input  logic                                      wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]                         wr_data_i,
  input  logic                                      rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]                         rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/tbs_lane.sv]
// one lane: signed agreement count over a slice of the bit planes
`timescale 1ns / 1ps
module tbs_lane import tbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [LANE_BITS-1:0] qp_i,
  input  logic [LANE_BITS-1:0] qn_i,
  input  logic [LANE_BITS-1:0] dp_i,
  input  logic [LANE_BITS-1:0] dn_i,
  output lane_delta_t          delta_o
);

  lane_delta_t delta_d;
  lane_delta_t delta_q;

  always_comb begin
    delta_d = $signed({{(LANE_DW - LANE_CW){1'b0}}, popcnt(qp_i & dp_i)})
            + $signed({{(LANE_DW - LANE_CW){1'b0}}, popcnt(qn_i & dn_i)})
            - $signed({{(LANE_DW - LANE_CW){1'b0}}, popcnt(qp_i & dn_i)})
            - $signed({{(LANE_DW - LANE_CW){1'b0}}, popcnt(qn_i & dp_i)});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      delta_q <= delta_d;
    end
  end

  assign delta_o = delta_q;

endmodule

[hdl/tbs_merge.sv]
// merge: sums lane counts into the saturating accumulator, output register
`timescale 1ns / 1ps
module tbs_merge import tbs_pkg::*; #(
  parameter int NUM_LANES = DEF_WORD_BITS / LANE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  tbs_ctrl_t                 ctrl_i,
  input  lane_delta_t               delta_i [NUM_LANES],
  output logic                      take_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic signed [SCORE_W-1:0] score_o,
  output logic [DOC_W-1:0]          doc_index_o
);

  logic signed [SCORE_W-1:0] acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic [DOC_W-1:0]          doc_q, doc_d;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SCORE_W-1:0] sat;

  // partial words never wait on the output register
  assign take_o = valid_i && (!ctrl_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    sum = ctrl_i.fresh ? '0 : SUM_W'(acc_q);
    for (int l = 0; l < NUM_LANES; l++) begin
      sum = sum + SUM_W'(delta_i[l]);
    end
    if (sum > SUM_HI) begin
      sat = SCORE_W'(SUM_HI);
    end else if (sum < SUM_LO) begin
      sat = SCORE_W'(SUM_LO);
    end else begin
      sat = SCORE_W'(sum);
    end
  end

  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    score_d     = score_q;
    doc_d       = doc_q;
    if (take_o) begin
      if (ctrl_i.last) begin
        acc_d       = '0;
        out_valid_d = 1'b1;
        score_d     = sat;
        doc_d       = ctrl_i.doc_index;
      end else begin
        acc_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    doc_q   <= doc_d;
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign doc_index_o = doc_q;

endmodule

[hdl/tbs_checker.sv]
// port-level checks of the scorer, bound to the top level
`timescale 1ns / 1ps
`include "ternary_bitplane_similarity_macros.svh"
module tbs_checker import tbs_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [SCORE_W-1:0] score,
  input logic [DOC_W-1:0]          doc_index,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [APB_AW-1:0]         paddr,
  input logic [APB_DW-1:0]         pwdata,
  input logic [APB_DW-1:0]         prdata,
  input logic                      pready
);

  // a waiting score beat keeps its payload
  `TBS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(score) && $stable(doc_index), "score beat changed while stalled")

  // with the output free the pipeline always drains, so input is never held off
  `TBS_ASSERT(a_in_ready_free, clk_i, rst_ni, (!out_valid || out_ready) |-> in_ready, "input stalled with free output")

  // register write reads back
  `TBS_ASSERT(a_cfg_readback, clk_i, rst_ni, psel && penable && pwrite && (paddr[2] == REG_WPV) |=> paddr[2] != REG_WPV || prdata[WPV_W-1:0] == $past(pwdata[WPV_W-1:0]), "words_per_vector readback mismatch")

  // configuration port never waits
  `TBS_ASSERT_ALWAYS(a_pready_high, clk_i, pready, "pready low")

endmodule

bind ternary_bitplane_similarity tbs_checker u_tbs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .score     (out_o.score),
  .doc_index (out_o.doc_index),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

[dv/tb.sv]
// self-checking testbench for the ternary bit-plane similarity scorer
`timescale 1ns / 1ps
module tb;
  import tbs_pkg::*;

  localparam int MAX_WORDS   = DEF_MAX_WORDS;
  localparam int WORD_BITS   = DEF_WORD_BITS;
  // query read, lane counts, merge into the output register
  localparam int PIPE_LAT    = 3;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SHOW_LIMIT  = 10;
  localparam logic [APB_AW-1:0] WPV_ADDR = APB_AW'(4 * int'(REG_WPV));
  localparam logic [PLANE_W-1:0] ALT_A = {32{2'b10}};
  localparam logic [PLANE_W-1:0] ALT_B = {32{2'b01}};

  // one score beat as the block should emit it
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [DOC_W-1:0]          doc_index;
  } score_beat_t;

  logic clk_i;
  logic rst_ni;

  tbs_in_if  in_bus ();
  tbs_out_if out_bus ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ternary_bitplane_similarity #(
    .MAX_WORDS(MAX_WORDS),
    .WORD_BITS(WORD_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow of the block: query store, running sum, word slot, document count
  logic [PLANE_W-1:0] shadow_qpos [MAX_WORDS];
  logic [PLANE_W-1:0] shadow_qneg [MAX_WORDS];
  int                 run_sum;
  int                 word_slot;
  logic [DOC_W-1:0]   docs_scored;
  logic [WPV_W-1:0]   vec_len_reg;

  // scores still owed by the block, oldest first
  score_beat_t pending_scores[$];

  int fail_count;
  int cycle_count;
  int send_gap_pct;
  int recv_gap_pct;
  bit hold_req;
  bit hold_out;

  // free-running clock, 4 ns period
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic [PLANE_W-1:0] plane_mask();
    if (WORD_BITS >= PLANE_W) begin
      return '1;
    end
    return (PLANE_W'(1) << WORD_BITS) - PLANE_W'(1);
  endfunction

  // effective vector length: zero acts as one, oversize clamps to the store depth
  function automatic int vec_words();
    if (vec_len_reg == '0) begin
      return 1;
    end
    if (int'(vec_len_reg) > MAX_WORDS) begin
      return MAX_WORDS;
    end
    return int'(vec_len_reg);
  endfunction

  // advances the shadow by one accepted beat and queues the score it closes
  function automatic void score_word(input op_e op, input logic [IDX_W-1:0] idx,
                                     input logic [PLANE_W-1:0] pos_in,
                                     input logic [PLANE_W-1:0] neg_in);
    logic [PLANE_W-1:0] dp;
    logic [PLANE_W-1:0] dn;
    logic [PLANE_W-1:0] qp;
    logic [PLANE_W-1:0] qn;
    int                 len;
    int                 slot;
    int                 sum;
    score_beat_t        beat;
    dp = pos_in & plane_mask();
    dn = neg_in & plane_mask();
    if (op == OP_LOAD) begin
      // a load always restarts scoring, even when the index misses the store
      if (int'(idx) < MAX_WORDS) begin
        shadow_qpos[idx] = dp;
        shadow_qneg[idx] = dn;
      end
      word_slot   = 0;
      run_sum     = 0;
      docs_scored = '0;
      return;
    end
    len  = vec_words();
    slot = (word_slot >= len) ? 0 : word_slot;
    qp   = shadow_qpos[slot] & plane_mask();
    qn   = shadow_qneg[slot] & plane_mask();
    sum  = run_sum + $countones(qp & dp) + $countones(qn & dn)
         - $countones(qp & dn) - $countones(qn & dp);
    if (sum > SCORE_MAX) begin
      sum = SCORE_MAX;
    end
    if (sum < SCORE_MIN) begin
      sum = SCORE_MIN;
    end
    if (slot + 1 >= len) begin
      beat.score     = SCORE_W'(sum);
      beat.doc_index = docs_scored;
      pending_scores.push_back(beat);
      docs_scored = docs_scored + DOC_W'(1);
      run_sum     = 0;
      word_slot   = 0;
    end else begin
      run_sum   = sum;
      word_slot = slot + 1;
    end
  endfunction

  function automatic logic [PLANE_W-1:0] rand_plane();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offers one beat from a falling edge and returns at the falling edge after
  // it was taken, valid still high so back-to-back beats need no re-raise
  task automatic send_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic [PLANE_W-1:0] pos_in,
                           input logic [PLANE_W-1:0] neg_in);
    while ($urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.word_index <= idx;
    in_bus.pos_bits   <= pos_in;
    in_bus.neg_bits   <= neg_in;
    do @(posedge clk_i); while (!in_bus.ready);
    score_word(op, idx, pos_in, neg_in);
    @(negedge clk_i);
  endtask

  task automatic doc_word(input logic [PLANE_W-1:0] pos_in, input logic [PLANE_W-1:0] neg_in);
    send_item(OP_DOC, IDX_W'($urandom_range(MAX_WORDS - 1)), pos_in, neg_in);
  endtask

  task automatic stop_input();
    in_bus.valid <= 1'b0;
  endtask

  // drain every owed score, then let any partial word clear the pipeline
  task automatic wait_drained();
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic set_vector_len(input logic [WPV_W-1:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WPV_ADDR;
    pwdata  <= APB_DW'(len);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    vec_len_reg = len;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly short vectors, a few long ones, now and then the out-of-range codes
  function automatic logic [WPV_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return WPV_W'($urandom_range(4, 1));
    end
    if (r < 85) begin
      return WPV_W'($urandom_range(16, 5));
    end
    if (r < 93) begin
      return WPV_W'($urandom_range(MAX_WORDS, 17));
    end
    case ($urandom_range(3))
      0: return '0;
      1: return WPV_W'(MAX_WORDS);
      2: return WPV_W'(MAX_WORDS + 1);
      default: return '1;
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    out_bus.ready <= !hold_out && ($urandom_range(99) >= recv_gap_pct);
  end

  always begin
    wait (hold_req);
    @(posedge clk_i);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_out = 1'b0;
    hold_req = 1'b0;
  end

  // score checker: each beat against the oldest owed score
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_scores.size() == 0) begin
        flag_error($sformatf("unexpected score beat: score %0d doc %0d",
                             out_bus.score, out_bus.doc_index));
      end else begin
        score_beat_t want;
        want = pending_scores.pop_front();
        if (out_bus.score !== want.score || out_bus.doc_index !== want.doc_index) begin
          flag_error($sformatf("mismatch: expected score %0d doc %0d, got score %0d doc %0d",
                               want.score, want.doc_index, out_bus.score, out_bus.doc_index));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // only query word 0 is written here, so the vector length stays at one;
  // covers full agreement, full conflict, both planes set and the counter
  task automatic test_directed();
    send_item(OP_LOAD, '0, '1, '0);
    doc_word('1, '0);
    doc_word('0, '1);
    doc_word('1, '1);
    doc_word('0, '0);
    send_item(OP_LOAD, '0, '0, '1);
    doc_word('1, '0);
    doc_word('0, '1);
    send_item(OP_LOAD, '0, '1, '1);
    doc_word(ALT_A, ALT_B);
    doc_word('1, '0);
    send_item(OP_LOAD, '0, ALT_B, ALT_A);
    doc_word(ALT_B, ALT_A);
    doc_word(ALT_A, ALT_B);
    doc_word({32'hFFFF_FFFF, 32'h0}, {32'h0, 32'hFFFF_FFFF});
    doc_word(ALT_B, '0);
    stop_input();
    wait_drained();
  endtask

  // writes every query slot so later vectors never read an unwritten entry
  task automatic test_fill_store();
    for (int i = 0; i < MAX_WORDS; i++) begin
      if (i == MAX_WORDS - 1) begin
        send_item(OP_LOAD, IDX_W'(i), '1, '0);
      end else begin
        send_item(OP_LOAD, IDX_W'(i), rand_plane(), rand_plane());
      end
    end
    stop_input();
    wait_drained();
  endtask

  // longest vector matched and anti-matched, length codes out of range,
  // and a vector cut short by a load
  task automatic test_vector_lengths();
    set_vector_len(WPV_W'(MAX_WORDS));
    for (int i = 0; i < MAX_WORDS; i++) begin
      doc_word(shadow_qpos[i], shadow_qneg[i]);
    end
    for (int i = 0; i < MAX_WORDS; i++) begin
      doc_word(shadow_qneg[i], shadow_qpos[i]);
    end
    stop_input();
    wait_drained();
    set_vector_len('0);
    doc_word(rand_plane(), rand_plane());
    doc_word(rand_plane(), rand_plane());
    stop_input();
    wait_drained();
    set_vector_len('1);
    for (int i = 0; i < MAX_WORDS + 3; i++) begin
      doc_word(rand_plane(), rand_plane());
    end
    stop_input();
    wait_drained();
    set_vector_len(WPV_W'(MAX_WORDS + 1));
    for (int i = 0; i < MAX_WORDS - 3; i++) begin
      doc_word(rand_plane(), rand_plane());
    end
    stop_input();
    wait_drained();
    set_vector_len(WPV_W'(3));
    doc_word(rand_plane(), rand_plane());
    doc_word(rand_plane(), rand_plane());
    send_item(OP_LOAD, IDX_W'($urandom_range(MAX_WORDS - 1)), rand_plane(), rand_plane());
    for (int i = 0; i < 6; i++) begin
      doc_word(rand_plane(), rand_plane());
    end
    stop_input();
    wait_drained();
  endtask

  // segments of document streams under random vector lengths, with a few
  // loads thrown in that break vectors and restart the document count
  task automatic test_random_stream(input int budget);
    int                 sent;
    int                 seg;
    logic [PLANE_W-1:0] p;
    logic [PLANE_W-1:0] n;
    sent = 0;
    while (sent < budget) begin
      set_vector_len(pick_len());
      seg = 3 * vec_words() + $urandom_range(30, 5);
      if (seg > 200) begin
        seg = 200;
      end
      for (int k = 0; k < seg; k++) begin
        p = rand_plane();
        n = ($urandom_range(1) == 0) ? (rand_plane() & ~p) : rand_plane();
        if ($urandom_range(99) < 3) begin
          send_item(OP_LOAD, IDX_W'($urandom_range(MAX_WORDS - 1)), p, n);
        end else begin
          doc_word(p, n);
        end
      end
      sent += seg;
      stop_input();
      wait_drained();
    end
  endtask

  // receiver holds off while the sender keeps offering: the block must fill
  // and drop input ready without losing or duplicating a score
  task automatic test_backpressure();
    set_vector_len(WPV_W'(1));
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      doc_word(rand_plane(), rand_plane());
    end
    stop_input();
    wait_drained();
  endtask

  initial begin
    fail_count        = 0;
    cycle_count       = 0;
    hold_req          = 1'b0;
    hold_out          = 1'b0;
    run_sum           = 0;
    word_slot         = 0;
    docs_scored       = '0;
    vec_len_reg       = WPV_W'(WPV_RESET);
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_LOAD;
    in_bus.word_index = '0;
    in_bus.pos_bits   = '0;
    in_bus.neg_bits   = '0;
    out_bus.ready     = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    send_gap_pct      = 25;
    recv_gap_pct      = 81;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_fill_store();
    test_vector_lengths();
    test_random_stream(40);
    send_gap_pct = 81;
    recv_gap_pct = 25;
    test_random_stream(40);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_backpressure();
    test_random_stream(40);

    if (pending_scores.size() != 0) begin
      flag_error($sformatf("%0d scores never arrived", pending_scores.size()));
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/tbs_pkg.sv
hdl/tbs_if.sv
hdl/tbs_query_mem.sv
hdl/tbs_lane.sv
hdl/tbs_merge.sv
hdl/ternary_bitplane_similarity.sv
hdl/tbs_checker.sv
dv/tb.sv
